@@ src/mwma_pkg.sv @@
// ----------------------------------------------------------------------------
// mwma_pkg
// Shared types and constant functions for the multi-window moving average.
// ----------------------------------------------------------------------------
`default_nettype none

package mwma_pkg;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RAW,
        ST_READ,
        ST_UPDATE,
        ST_DIVIDE,
        ST_EMIT
    } mwma_state_t;

    // Field widths fixed by the interface
    localparam int SAMPLE_W = 24;
    localparam int LENGTH_W = 9;
    localparam int COUNT_W  = 32;
    localparam int TOTAL_W  = 56;

    // Number of fixed windows for a given history size
    function automatic int win_count(input int max_w);
        int len;
        int n;
        len = 2;
        n   = 0;
        while (len <= max_w - 20)
        begin
            n   = n + 1;
            len = (6 * len) / 5 + 15;
        end
        return n;
    endfunction

    // Length of fixed window number k
    function automatic int win_len(input int k);
        int len;
        len = 2;
        for (int i = 0; i < k; i++)
        begin
            len = (6 * len) / 5 + 15;
        end
        return len;
    endfunction

endpackage

`default_nettype wire

@@ src/multi_window_moving_average_unit.sv @@
// ----------------------------------------------------------------------------
// multi_window_moving_average_unit
// Running means over several fixed windows of a sample stream, plus the raw
// value and the mean of every sample since reset.
// ----------------------------------------------------------------------------
// Usage: the input channel (in_valid / in_stall) takes one beat of
// sample_index and sample_value. Each beat yields, in order, the raw value
// tagged window_length 0, one mean for each window whose length is reached by
// both the index and the stored sample count, and the mean of all samples
// when the index reaches MAX_WINDOW. last_of_run marks the final result beat.
// Window sums are kept per window and updated incrementally: each window
// needs one history read whether it emits or not, and each mean takes one
// pass of the shared radix-2 divider before it is emitted. The input stalls
// until the item is finished. The output register holds a beat while
// out_stall is high, and the sequencer waits on it. Reset clears the
// pointer, count, total and window sums; the history memory needs no
// clearing, as an entry read before enough samples have been written
// is never used in a window sum.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_window_moving_average_unit #(
    parameter int MAX_WINDOW = 256
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic [mwma_pkg::SAMPLE_W-1:0]      sample_index,
    input  wire logic signed [mwma_pkg::SAMPLE_W-1:0] sample_value,
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic [mwma_pkg::LENGTH_W-1:0]           window_length,
    output logic signed [mwma_pkg::SAMPLE_W-1:0]    average_value,
    output logic                                    last_of_run
);
    import mwma_pkg::*;

    localparam int NWIN = win_count(MAX_WINDOW);
    localparam int KW   = $clog2(NWIN);
    localparam int AW   = $clog2(MAX_WINDOW);
    localparam int LW   = $clog2(MAX_WINDOW + 1);
    localparam int SW   = SAMPLE_W + AW + 1;
    localparam int DCW  = $clog2(TOTAL_W);

    // Constant table of window lengths
    logic [LW-1:0] win_len_tab [NWIN];
    for (genvar g = 0; g < NWIN; g++)
    begin : g_len
        assign win_len_tab[g] = LW'(win_len(g));
    end

    mwma_state_t state_reg, state_next;

    logic [AW-1:0]              wp_reg;
    logic [AW-1:0]              base_reg;
    logic [COUNT_W-1:0]         stored_reg;
    logic signed [TOTAL_W-1:0]  total_reg;
    logic [LW-1:0]              avail_prev_reg;
    logic [SAMPLE_W-1:0]        idx_reg;
    logic signed [SAMPLE_W-1:0] val_reg;
    logic [KW-1:0]              k_reg;
    logic                       tot_phase_reg;
    logic signed [SW-1:0]       win_sum_reg [NWIN];

    logic [SAMPLE_W-1:0]        hist [MAX_WINDOW];
    logic [SAMPLE_W-1:0]        rd_data_reg;

    logic [COUNT_W-1:0]         rem_reg;
    logic [TOTAL_W-1:0]         quo_reg;
    logic [COUNT_W-1:0]         divisor_reg;
    logic                       neg_reg;
    logic [DCW-1:0]             cnt_reg;

    logic                       out_valid_reg;
    logic [LENGTH_W-1:0]        out_len_reg;
    logic signed [SAMPLE_W-1:0] out_avg_reg;
    logic                       out_last_reg;

    // Control strobes from the sequencer
    logic in_accept;
    logic out_free;
    logic emit_raw;
    logic emit_mean;
    logic do_read;
    logic do_update;
    logic load_win;
    logic load_tot;
    logic step_k;

    // Window status for the current and the next window
    logic [LW-1:0]   cur_len;
    logic            more_k;
    logic [KW-1:0]   k_next;
    logic            ready_cur;
    logic            ready_nxt;
    logic            tot_due;
    logic [LW:0]     addr_wide;
    logic [AW-1:0]   rd_addr;
    logic signed [SW-1:0] sum_new;
    logic signed [SW-1:0] old_term;

    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign cur_len   = win_len_tab[k_reg];
    assign more_k    = (k_reg != KW'(NWIN - 1));
    assign k_next    = more_k ? KW'(k_reg + 1'b1) : k_reg;
    assign ready_cur = (idx_reg >= SAMPLE_W'(cur_len)) && (stored_reg >= COUNT_W'(cur_len));
    assign ready_nxt = more_k && (idx_reg >= SAMPLE_W'(win_len_tab[k_next]))
                       && (stored_reg >= COUNT_W'(win_len_tab[k_next]));
    assign tot_due   = (idx_reg >= SAMPLE_W'(MAX_WINDOW));

    // Address of the sample leaving the current window
    always_comb
    begin
        addr_wide = (LW+1)'(base_reg) + (LW+1)'(MAX_WINDOW) - (LW+1)'(cur_len);
        if (addr_wide >= (LW+1)'(MAX_WINDOW))
        begin
            addr_wide = addr_wide - (LW+1)'(MAX_WINDOW);
        end
        rd_addr = addr_wide[AW-1:0];
    end

    // New window sum: add the newest sample, drop the oldest once the window is full
    always_comb
    begin
        old_term = (avail_prev_reg >= cur_len)
                 ? SW'(signed'(rd_data_reg)) : '0;
        sum_new  = win_sum_reg[k_reg] + SW'(val_reg) - old_term;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_RAW;
                end
            end
            ST_RAW:
            begin
                if (out_free)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                if (ready_cur || (!more_k && tot_due))
                begin
                    state_next = ST_DIVIDE;
                end
                else if (more_k)
                begin
                    state_next = ST_READ;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_DIVIDE:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    if (tot_phase_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (more_k)
                    begin
                        state_next = ST_READ;
                    end
                    else if (tot_due)
                    begin
                        state_next = ST_DIVIDE;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        in_stall  = (state_reg != ST_IDLE);
        emit_raw  = 1'b0;
        emit_mean = 1'b0;
        do_read   = 1'b0;
        do_update = 1'b0;
        load_win  = 1'b0;
        load_tot  = 1'b0;
        step_k    = 1'b0;
        case (state_reg)
            ST_RAW:
            begin
                emit_raw = out_free;
            end
            ST_READ:
            begin
                do_read = 1'b1;
            end
            ST_UPDATE:
            begin
                do_update = 1'b1;
                load_win  = ready_cur;
                load_tot  = !ready_cur && !more_k && tot_due;
                step_k    = !ready_cur && more_k;
            end
            ST_EMIT:
            begin
                emit_mean = out_free;
                step_k    = out_free && !tot_phase_reg && more_k;
                load_tot  = out_free && !tot_phase_reg && !more_k && tot_due;
            end
            default:
            begin
                emit_raw = 1'b0;
            end
        endcase
    end

    // Control registers and window sums
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wp_reg        <= '0;
            stored_reg    <= '0;
            total_reg     <= '0;
            k_reg         <= '0;
            tot_phase_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NWIN; i++)
            begin
                win_sum_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (in_accept)
            begin
                wp_reg        <= (wp_reg == AW'(MAX_WINDOW - 1)) ? '0 : AW'(wp_reg + 1'b1);
                k_reg         <= '0;
                tot_phase_reg <= 1'b0;
                if (stored_reg != '1)
                begin
                    stored_reg <= stored_reg + 1'b1;
                    total_reg  <= total_reg + TOTAL_W'(sample_value);
                end
            end
            if (do_update)
            begin
                win_sum_reg[k_reg] <= sum_new;
            end
            if (step_k)
            begin
                k_reg <= k_next;
            end
            if (load_tot)
            begin
                tot_phase_reg <= 1'b1;
            end
            if (emit_raw || emit_mean)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Beat payload, divider datapath and latched item fields
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            base_reg       <= wp_reg;
            idx_reg        <= sample_index;
            val_reg        <= sample_value;
            avail_prev_reg <= (stored_reg >= COUNT_W'(MAX_WINDOW))
                            ? LW'(MAX_WINDOW) : stored_reg[LW-1:0];
        end
        if (load_win)
        begin
            neg_reg     <= sum_new[SW-1];
            quo_reg     <= sum_new[SW-1] ? TOTAL_W'(-sum_new) : TOTAL_W'(sum_new);
            rem_reg     <= '0;
            divisor_reg <= COUNT_W'(cur_len);
            cnt_reg     <= DCW'(TOTAL_W - 1);
        end
        else if (load_tot)
        begin
            neg_reg     <= total_reg[TOTAL_W-1];
            quo_reg     <= total_reg[TOTAL_W-1] ? TOTAL_W'(-total_reg) : total_reg;
            rem_reg     <= '0;
            divisor_reg <= stored_reg;
            cnt_reg     <= DCW'(TOTAL_W - 1);
        end
        else if (state_reg == ST_DIVIDE)
        begin
            // Advance one quotient bit
            if ({rem_reg, quo_reg[TOTAL_W-1]} >= {1'b0, divisor_reg})
            begin
                rem_reg <= COUNT_W'({rem_reg, quo_reg[TOTAL_W-1]} - {1'b0, divisor_reg});
                quo_reg <= {quo_reg[TOTAL_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= {rem_reg[COUNT_W-2:0], quo_reg[TOTAL_W-1]};
                quo_reg <= {quo_reg[TOTAL_W-2:0], 1'b0};
            end
            cnt_reg <= cnt_reg - 1'b1;
        end
        if (emit_raw)
        begin
            out_len_reg  <= '0;
            out_avg_reg  <= val_reg;
            out_last_reg <= !ready_cur && !tot_due;
        end
        else if (emit_mean)
        begin
            out_len_reg  <= tot_phase_reg ? LENGTH_W'(MAX_WINDOW) : LENGTH_W'(cur_len);
            out_avg_reg  <= neg_reg ? SAMPLE_W'(-quo_reg) : SAMPLE_W'(quo_reg);
            out_last_reg <= tot_phase_reg || (!ready_nxt && !tot_due);
        end
    end

    // History memory: write the new sample at accept, read one leaving sample.
    // The read slot never equals the slot just written, so no forwarding.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            hist[wp_reg] <= sample_value;
        end
        if (do_read)
        begin
            rd_data_reg <= hist[rd_addr];
        end
    end

    assign out_valid     = out_valid_reg;
    assign window_length = out_len_reg;
    assign average_value = out_avg_reg;
    assign last_of_run   = out_last_reg;

    // Checks
    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIVIDE) |-> (divisor_reg != '0))
        else $error("divider running with zero divisor");

    a_wp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !in_accept |=> $stable(wp_reg))
        else $error("write pointer moved without an input beat");

    a_k_range: assert property (@(posedge clk) disable iff (!rst_n)
        k_reg <= KW'(NWIN - 1))
        else $error("window index out of range");

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        (emit_raw || emit_mean) |-> out_free)
        else $error("result loaded over a held beat");

endmodule

`default_nettype wire
